>>> design/nnis_pkg.sv
// Shared constants and types for the nearest-neighbor image scaler.
package nnis_pkg;

  localparam int PIX_W      = 32;
  localparam int SRC_DIM_W  = 9;
  localparam int DST_DIM_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_FORMAT = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic FMT_RGB  = 1'b0;
  localparam logic FMT_RGBA = 1'b1;

  localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

endpackage

>>> design/nnis_fifo.sv
// Small register queue with full/empty status, used for commands and results.
module nnis_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/nnis_front.sv
// Front end: accepts input words, assigns load addresses, queues commands.
module nnis_front #(
  parameter int MAX_SRC_DIM = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_push,
  output logic                                     in_full,
  input  logic                                     in_opcode,
  input  logic [nnis_pkg::PIX_W-1:0]               in_pixel_in,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]         sw,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]         sh,
  input  logic                                     cmd_full,
  output logic                                     cmd_push,
  output logic [$clog2(MAX_SRC_DIM*MAX_SRC_DIM)+nnis_pkg::PIX_W:0] cmd_wdata
);
  import nnis_pkg::*;

  localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
  localparam int AW     = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int CNT_W  = 2 * SW_W;
  localparam int CNT_W1 = CNT_W + 1;

  logic [AW-1:0]     load_ptr_r, load_ptr_nxt;
  logic [CNT_W-1:0]  frame_cnt;
  logic [CNT_W1-1:0] ptr_inc;
  logic              accept;

  assign in_full   = cmd_full;
  assign accept    = in_push && !cmd_full;
  assign cmd_push  = accept;
  assign cmd_wdata = {load_ptr_r, in_opcode, in_pixel_in};

  assign frame_cnt = CNT_W'(sw) * CNT_W'(sh);
  assign ptr_inc   = CNT_W1'(load_ptr_r) + CNT_W1'(1);

  always_comb begin
    load_ptr_nxt = load_ptr_r;
    if (accept && (in_opcode == OP_LOAD)) begin
      load_ptr_nxt = (ptr_inc >= CNT_W1'(frame_cnt)) ? '0 : AW'(ptr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r <= '0;
    end else begin
      load_ptr_r <= load_ptr_nxt;
    end
  end

endmodule

>>> design/nnis_back.sv
// Back end: frame store, destination walk and accumulator stepping.
module nnis_back #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cmd_empty,
  input  logic [$clog2(MAX_SRC_DIM*MAX_SRC_DIM)+nnis_pkg::PIX_W:0] cmd_rdata,
  output logic                                     cmd_pop,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]         sw,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]         sh,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]         dw,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]         dh,
  input  logic                                     pixel_format,
  input  logic                                     res_full,
  output logic                                     res_push,
  output logic [nnis_pkg::PIX_W-1:0]               res_pixel,
  output nnis_pkg::flags_t                         res_flags
);
  import nnis_pkg::*;

  localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
  localparam int SC_W   = $clog2(MAX_SRC_DIM);
  localparam int DW_W   = $clog2(MAX_DST_DIM + 1);
  localparam int DC_W   = $clog2(MAX_DST_DIM);
  localparam int AW     = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int PR_W   = SC_W + SW_W;
  localparam int ACC_W  = $clog2(MAX_DST_DIM + MAX_SRC_DIM + 1);
  localparam int CMD_W  = AW + PIX_W + 1;
  localparam int DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam logic [SC_W-1:0] SC_MAX = SC_W'(MAX_SRC_DIM - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_STEP = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [DC_W-1:0] dest_col_r, dest_col_nxt;
  logic [DC_W-1:0] dest_row_r, dest_row_nxt;
  logic [SC_W-1:0] src_col_r, src_col_nxt;
  logic [SC_W-1:0] src_row_r, src_row_nxt;
  logic [ACC_W-1:0] col_acc_r, col_acc_nxt;
  logic [ACC_W-1:0] row_acc_r, row_acc_nxt;
  logic            sel_row_r, sel_row_nxt;
  flags_t          flags_r, flags_nxt;

  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] mem_q_r;

  logic             cmd_op;
  logic [AW-1:0]    cmd_addr;
  logic [PIX_W-1:0] cmd_pix;
  logic [SC_W-1:0]  col_c, row_c;
  logic [PR_W-1:0]  prod;
  logic [AW-1:0]    rd_addr;
  logic             rend_now, fend_now;
  logic             load_go, emit_go;
  logic [ACC_W-1:0] col_sum, row_sum, acc_cur, acc_diff, dec;

  function automatic logic [SC_W-1:0] sat_inc(input logic [SC_W-1:0] p);
    return (p == SC_MAX) ? p : p + 1'b1;
  endfunction

  assign cmd_op   = cmd_rdata[PIX_W];
  assign cmd_addr = cmd_rdata[CMD_W-1 -: AW];
  assign cmd_pix  = cmd_rdata[PIX_W-1:0];

  assign col_c   = (SW_W'(src_col_r) < sw) ? src_col_r : SC_W'(sw - SW_W'(1));
  assign row_c   = (SW_W'(src_row_r) < sh) ? src_row_r : SC_W'(sh - SW_W'(1));
  assign prod    = PR_W'(row_c) * PR_W'(sw) + PR_W'(col_c);
  assign rd_addr = prod[AW-1:0];

  assign rend_now = (DW_W'(dest_col_r) + DW_W'(1)) >= dw;
  assign fend_now = rend_now && ((DW_W'(dest_row_r) + DW_W'(1)) >= dh);

  assign load_go = (state_r == ST_IDLE) && !cmd_empty && (cmd_op == OP_LOAD);
  assign emit_go = (state_r == ST_IDLE) && !cmd_empty && (cmd_op == OP_EMIT) && !res_full;
  assign cmd_pop = load_go || emit_go;

  assign col_sum  = col_acc_r + ACC_W'(sw);
  assign row_sum  = row_acc_r + ACC_W'(sh);
  assign acc_cur  = sel_row_r ? row_acc_r : col_acc_r;
  assign dec      = sel_row_r ? ACC_W'(dh) : ACC_W'(dw);
  assign acc_diff = acc_cur - dec;

  assign res_push  = (state_r == ST_READ);
  assign res_pixel = (pixel_format == FMT_RGBA) ? mem_q_r : (mem_q_r & RGB_MASK);
  assign res_flags = flags_r;

  always_comb begin
    state_nxt    = state_r;
    dest_col_nxt = dest_col_r;
    dest_row_nxt = dest_row_r;
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    col_acc_nxt  = col_acc_r;
    row_acc_nxt  = row_acc_r;
    sel_row_nxt  = sel_row_r;
    flags_nxt    = flags_r;
    case (state_r)
      ST_IDLE: begin
        if (emit_go) begin
          flags_nxt.row_end   = rend_now;
          flags_nxt.frame_end = fend_now;
          state_nxt           = ST_READ;
        end
      end
      ST_READ: begin
        if (!flags_r.row_end) begin
          col_acc_nxt  = col_sum;
          dest_col_nxt = dest_col_r + 1'b1;
          sel_row_nxt  = 1'b0;
          state_nxt    = (col_sum > ACC_W'(dw)) ? ST_STEP : ST_IDLE;
        end else begin
          dest_col_nxt = '0;
          src_col_nxt  = '0;
          col_acc_nxt  = '0;
          if (flags_r.frame_end) begin
            dest_row_nxt = '0;
            src_row_nxt  = '0;
            row_acc_nxt  = '0;
            state_nxt    = ST_IDLE;
          end else begin
            row_acc_nxt  = row_sum;
            dest_row_nxt = dest_row_r + 1'b1;
            sel_row_nxt  = 1'b1;
            state_nxt    = (row_sum > ACC_W'(dh)) ? ST_STEP : ST_IDLE;
          end
        end
      end
      ST_STEP: begin
        if (sel_row_r) begin
          row_acc_nxt = acc_diff;
          src_row_nxt = sat_inc(src_row_r);
        end else begin
          col_acc_nxt = acc_diff;
          src_col_nxt = sat_inc(src_col_r);
        end
        state_nxt = (acc_diff > dec) ? ST_STEP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dest_col_r <= '0;
      dest_row_r <= '0;
      src_col_r  <= '0;
      src_row_r  <= '0;
      col_acc_r  <= '0;
      row_acc_r  <= '0;
      sel_row_r  <= 1'b0;
      flags_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      dest_col_r <= dest_col_nxt;
      dest_row_r <= dest_row_nxt;
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      col_acc_r  <= col_acc_nxt;
      row_acc_r  <= row_acc_nxt;
      sel_row_r  <= sel_row_nxt;
      flags_r    <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      frame_mem[cmd_addr] <= cmd_pix;
    end
    mem_q_r <= frame_mem[rd_addr];
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_emit_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (state_r == ST_READ))
    else $error("emit did not reach read");

  a_step_needs_excess: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (acc_cur > dec))
    else $error("step entered without accumulator excess");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && flags_r.frame_end) |=> (dest_row_r == '0 && dest_col_r == '0))
    else $error("frame end did not restart walk");

endmodule

>>> design/nearest_neighbor_image_scaler_unit.sv
// Top level of the nearest-neighbor image scaler: config registers and queues.
// Load words write source pixels in raster order into an on-chip frame store
// of MAX_SRC_DIM*MAX_SRC_DIM words (no clearing pass; read only what was
// loaded); emit words return the next destination pixel in raster order.
// The front end takes one word per cycle while the 4-entry command queue has room.
// In the back end a load only writes the frame store; an emit goes from idle to
// a read state that pushes the result, then through one step state per source
// column (or row, at a row end) the walk advances, about src/dst size rounded; the
// stepping loop does one subtraction per cycle. Results wait in a 2-entry queue.
module nearest_neighbor_image_scaler_unit #(
  parameter int MAX_SRC_DIM = 256,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_opcode,
  input  logic [nnis_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [nnis_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                            out_row_end,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nnis_pkg::*;

  localparam int SW_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int DW_W  = $clog2(MAX_DST_DIM + 1);
  localparam int AW    = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int CMD_W = AW + PIX_W + 1;
  localparam int RES_W = PIX_W + FLAGS_W;

  logic [SRC_DIM_W-1:0] src_width_r, src_height_r;
  logic [DST_DIM_W-1:0] dst_width_r, dst_height_r;
  logic                 pixel_format_r;

  logic [SW_W-1:0] sw, sh;
  logic [DW_W-1:0] dw, dh;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic             res_push, res_full;
  logic [PIX_W-1:0] res_pixel;
  flags_t           res_flags, out_flags;
  logic [RES_W-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= SRC_DIM_W'(1);
      src_height_r   <= SRC_DIM_W'(1);
      dst_width_r    <= DST_DIM_W'(1);
      dst_height_r   <= DST_DIM_W'(1);
      pixel_format_r <= FMT_RGB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_r    <= cfg_wdata[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r   <= cfg_wdata[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_width_r    <= cfg_wdata[DST_DIM_W-1:0];
        REG_DST_HEIGHT: dst_height_r   <= cfg_wdata[DST_DIM_W-1:0];
        REG_PIX_FORMAT: pixel_format_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the max
  always_comb begin
    if (src_width_r == '0) sw = SW_W'(1);
    else if (32'(src_width_r) > MAX_SRC_DIM) sw = SW_W'(MAX_SRC_DIM);
    else sw = SW_W'(src_width_r);
    if (src_height_r == '0) sh = SW_W'(1);
    else if (32'(src_height_r) > MAX_SRC_DIM) sh = SW_W'(MAX_SRC_DIM);
    else sh = SW_W'(src_height_r);
    if (dst_width_r == '0) dw = DW_W'(1);
    else if (32'(dst_width_r) > MAX_DST_DIM) dw = DW_W'(MAX_DST_DIM);
    else dw = DW_W'(dst_width_r);
    if (dst_height_r == '0) dh = DW_W'(1);
    else if (32'(dst_height_r) > MAX_DST_DIM) dh = DW_W'(MAX_DST_DIM);
    else dh = DW_W'(dst_height_r);
  end

  nnis_front #(
    .MAX_SRC_DIM (MAX_SRC_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_opcode   (in_opcode),
    .in_pixel_in (in_pixel_in),
    .sw          (sw),
    .sh          (sh),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_wdata   (cmd_wdata)
  );

  nnis_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  nnis_back #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_empty    (cmd_empty),
    .cmd_rdata    (cmd_rdata),
    .cmd_pop      (cmd_pop),
    .sw           (sw),
    .sh           (sh),
    .dw           (dw),
    .dh           (dh),
    .pixel_format (pixel_format_r),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_pixel    (res_pixel),
    .res_flags    (res_flags)
  );

  nnis_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_flags, res_pixel}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_flags     = res_rdata[RES_W-1:PIX_W];
  assign out_pixel_out = res_rdata[PIX_W-1:0];
  assign out_row_end   = out_flags.row_end;
  assign out_frame_end = out_flags.frame_end;

endmodule

>>> tb/nearest_neighbor_image_scaler_unit_tb.sv
// Testbench for the nearest-neighbor image scaler: directed table, then random frames.
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_unit_tb;
  import nnis_pkg::*;

  localparam int MAX_SRC      = 256;
  localparam int MAX_DST      = 4096;
  localparam int FRAME_WORDS  = MAX_SRC * MAX_SRC;
  localparam int WORD_TARGET  = 1300;
  localparam int DRAIN_CYCLES = 12;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    flags_t           flags;
  } scaled_pixel_t;

  typedef struct packed {
    logic [31:0]          steps;
    logic [DST_DIM_W-1:0] acc;
  } acc_step_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  opcode;
    logic [PIX_W-1:0]      pixel;
    logic                  known;
    scaled_pixel_t         result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_opcode = OP_LOAD;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_row_end;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // scaler model state
  logic [SRC_DIM_W-1:0] reg_src_w, reg_src_h;
  logic [DST_DIM_W-1:0] reg_dst_w, reg_dst_h;
  logic                 reg_format;
  logic [PIX_W-1:0]     frame_store [FRAME_WORDS];
  bit                   frame_loaded [FRAME_WORDS];
  logic [15:0]          load_ptr;
  logic [11:0]          dst_col, dst_row;
  logic [7:0]           src_col, src_row;
  logic [DST_DIM_W-1:0] col_acc, row_acc;

  scaled_pixel_t pending_pixels[$];
  int            words_sent = 0;
  int            words_checked = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int unsigned   settle_cycles = 0;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;

  nearest_neighbor_image_scaler_unit #(
    .MAX_SRC_DIM(MAX_SRC),
    .MAX_DST_DIM(MAX_DST)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_opcode(in_opcode),
    .in_pixel_in(in_pixel_in),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pixel_out(out_pixel_out),
    .out_row_end(out_row_end),
    .out_frame_end(out_frame_end),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic logic [15:0] pick_addr();
    int unsigned sw, sh, c, r;
    sw = eff_dim(reg_src_w, MAX_SRC);
    sh = eff_dim(reg_src_h, MAX_SRC);
    c = (src_col < sw) ? src_col : sw - 1;
    r = (src_row < sh) ? src_row : sh - 1;
    return 16'((r * sw + c) % FRAME_WORDS);
  endfunction

  function automatic acc_step_t acc_step(int unsigned acc, int unsigned inc, int unsigned dec);
    acc_step_t   st;
    int unsigned a;
    a = acc + inc;
    st.steps = 0;
    if (a > dec) begin
      st.steps = (a - 1) / dec;
      a = a - st.steps * dec;
    end
    st.acc = DST_DIM_W'(a);
    return st;
  endfunction

  function automatic logic [7:0] advance_pos(logic [7:0] pos, int unsigned k);
    int unsigned s;
    s = pos + k;
    if (s > MAX_SRC - 1) s = MAX_SRC - 1;
    return 8'(s);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.index = index;
    row.data = data;
    return row;
  endfunction

  function automatic stim_row_t word_row(logic opcode, logic [PIX_W-1:0] pixel);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.opcode = opcode;
    row.pixel = pixel;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [PIX_W-1:0] pixel, flags_t flags);
    stim_row_t row;
    row = word_row(OP_EMIT, $urandom);
    row.known = 1'b1;
    row.result.pixel = pixel;
    row.result.flags = flags;
    return row;
  endfunction

  // advance the model by one accepted word; emits queue their expected pixel
  task automatic scale_word(input logic opcode, input logic [PIX_W-1:0] pixel,
                            input logic known, input scaled_pixel_t known_result);
    int unsigned   sw, sh, dw, dh;
    scaled_pixel_t res;
    acc_step_t     st;
    sw = eff_dim(reg_src_w, MAX_SRC);
    sh = eff_dim(reg_src_h, MAX_SRC);
    dw = eff_dim(reg_dst_w, MAX_DST);
    dh = eff_dim(reg_dst_h, MAX_DST);
    if (opcode == OP_LOAD) begin
      frame_store[load_ptr] = pixel;
      frame_loaded[load_ptr] = 1'b1;
      load_ptr = (load_ptr + 1 >= sw * sh) ? '0 : load_ptr + 1'b1;
    end else begin
      res.pixel = frame_store[pick_addr()];
      if (reg_format == FMT_RGB) res.pixel = res.pixel & RGB_MASK;
      res.flags.row_end = (dst_col + 1 >= dw);
      res.flags.frame_end = res.flags.row_end && (dst_row + 1 >= dh);
      pending_pixels.push_back(known ? known_result : res);
      // the back end keeps stepping after the result leaves, once per position advanced
      settle_cycles = 0;
      if (!res.flags.row_end) begin
        st = acc_step(col_acc, sw, dw);
        settle_cycles = st.steps;
        col_acc = st.acc;
        src_col = advance_pos(src_col, st.steps);
        dst_col = dst_col + 1'b1;
      end else begin
        dst_col = '0;
        src_col = '0;
        col_acc = '0;
        if (res.flags.frame_end) begin
          dst_row = '0;
          src_row = '0;
          row_acc = '0;
        end else begin
          st = acc_step(row_acc, sh, dh);
          settle_cycles = st.steps;
          row_acc = st.acc;
          src_row = advance_pos(src_row, st.steps);
          dst_row = dst_row + 1'b1;
        end
      end
    end
  endtask

  task automatic send_word(input logic opcode, input logic [PIX_W-1:0] pixel,
                           input logic known, input scaled_pixel_t known_result);
    int unsigned gap;
    in_push <= 1'b1;
    in_opcode <= opcode;
    in_pixel_in <= pixel;
    do @(posedge clk); while (in_full !== 1'b0);
    scale_word(opcode, pixel, known, known_result);
    words_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // emits that would hit a never-loaded entry become loads
  task automatic send_random(input logic want_emit);
    if (want_emit && frame_loaded[pick_addr()]) send_word(OP_EMIT, $urandom, 1'b0, '0);
    else send_word(OP_LOAD, $urandom, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + settle_cycles) @(posedge clk);
    settle_cycles = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    case (index)
      REG_SRC_WIDTH:  reg_src_w = data[SRC_DIM_W-1:0];
      REG_SRC_HEIGHT: reg_src_h = data[SRC_DIM_W-1:0];
      REG_DST_WIDTH:  reg_dst_w = data[DST_DIM_W-1:0];
      REG_DST_HEIGHT: reg_dst_h = data[DST_DIM_W-1:0];
      REG_PIX_FORMAT: reg_format = data[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int phase_no);
    logic [CFG_DATA_W-1:0] v [4];
    int unsigned           r, sw, sh, dw, dh, frame_len, n;
    bit                    hold;
    hold = (phase_no % 7 == 2);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v[0] = CFG_DATA_W'($urandom_range(1, 6));
      v[1] = CFG_DATA_W'($urandom_range(1, 6));
      v[2] = CFG_DATA_W'($urandom_range(1, 12));
      v[3] = CFG_DATA_W'($urandom_range(1, 10));
    end else if (r < 78) begin
      v[0] = CFG_DATA_W'($urandom_range(200, 511));
      v[1] = CFG_DATA_W'($urandom_range(0, 1));
      v[2] = CFG_DATA_W'($urandom_range(1, 3));
      v[3] = CFG_DATA_W'($urandom_range(1, 2));
    end else if (r < 86) begin
      v[0] = CFG_DATA_W'($urandom_range(0, 1));
      v[1] = CFG_DATA_W'($urandom_range(200, 511));
      v[2] = CFG_DATA_W'($urandom_range(1, 3));
      v[3] = CFG_DATA_W'($urandom_range(1, 3));
    end else if (r < 94) begin
      // high bits above the source register width are dropped
      v[0] = {4'($urandom), 9'($urandom_range(1, 4))};
      v[1] = {4'($urandom), 9'($urandom_range(1, 4))};
      v[2] = CFG_DATA_W'($urandom_range(4000, 8191));
      v[3] = CFG_DATA_W'($urandom_range(0, 3));
    end else begin
      v[0] = CFG_DATA_W'($urandom_range(0, 3));
      v[1] = CFG_DATA_W'($urandom_range(0, 3));
      v[2] = CFG_DATA_W'($urandom);
      v[3] = CFG_DATA_W'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      if (i < 2 || $urandom_range(0, 4) != 0) write_reg(CFG_IDX_W'(REG_SRC_WIDTH + i), v[i]);
    end
    if ($urandom_range(0, 1) != 0) write_reg(REG_PIX_FORMAT, CFG_DATA_W'($urandom));

    calm = hold || ($urandom_range(0, 4) == 0);
    sw = eff_dim(reg_src_w, MAX_SRC);
    sh = eff_dim(reg_src_h, MAX_SRC);
    dw = eff_dim(reg_dst_w, MAX_DST);
    dh = eff_dim(reg_dst_h, MAX_DST);
    frame_len = sw * sh;
    r = $urandom_range(0, 99);
    if (hold || r < 75) begin
      n = (hold || r < 60) ? frame_len : $urandom_range(1, frame_len);
      repeat (n) send_random(1'b0);
      n = dw * dh;
      if (n > 60) n = 60;
      if (hold) begin
        n = 24;
        hold_req = 1'b1;
      end
      repeat (n) send_random(1'b1);
    end
    repeat ($urandom_range(0, 12)) send_random(1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned   wait_left, hold_left;
    scaled_pixel_t want;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0) begin
        if (pending_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected word: pixel %h row_end %b frame_end %b",
                                  out_pixel_out, out_row_end, out_frame_end));
        end else begin
          want = pending_pixels.pop_front();
          if (out_pixel_out !== want.pixel || out_row_end !== want.flags.row_end ||
              out_frame_end !== want.flags.frame_end) begin
            note_mismatch($sformatf(
              "word %0d: expected pixel %h row_end %b frame_end %b, got %h %b %b",
              words_checked, want.pixel, want.flags.row_end, want.flags.frame_end,
              out_pixel_out, out_row_end, out_frame_end));
          end
        end
        words_checked++;
        wait_left = pick_gap();
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int        phase_no;
    phase_no = 0;
    reg_src_w = SRC_DIM_W'(1);
    reg_src_h = SRC_DIM_W'(1);
    reg_dst_w = DST_DIM_W'(1);
    reg_dst_h = DST_DIM_W'(1);
    reg_format = FMT_RGB;
    load_ptr = '0;
    dst_col = '0;
    dst_row = '0;
    src_col = '0;
    src_row = '0;
    col_acc = '0;
    row_acc = '0;

    // 1x1 after reset: every emit ends row and frame
    rows.push_back(word_row(OP_LOAD, 32'hA1B2_C3D4));
    rows.push_back(known_row(32'h00B2_C3D4, 2'b11));
    rows.push_back(reg_row(REG_PIX_FORMAT, CFG_DATA_W'(FMT_RGBA)));
    rows.push_back(known_row(32'hA1B2_C3D4, 2'b11));
    rows.push_back(word_row(OP_LOAD, 32'hFFFF_FFFF));
    rows.push_back(reg_row(REG_PIX_FORMAT + 3'd1, '1));
    rows.push_back(reg_row('1, '1));
    rows.push_back(known_row(32'hFFFF_FFFF, 2'b11));
    rows.push_back(word_row(OP_LOAD, 32'h0000_0000));
    rows.push_back(known_row(32'h0000_0000, 2'b11));
    // 2x1 source up to 5x2
    rows.push_back(reg_row(REG_SRC_WIDTH, 13'd2));
    rows.push_back(reg_row(REG_DST_WIDTH, 13'd5));
    rows.push_back(reg_row(REG_DST_HEIGHT, 13'd2));
    rows.push_back(reg_row(REG_PIX_FORMAT, CFG_DATA_W'(FMT_RGB)));
    rows.push_back(word_row(OP_LOAD, 32'h1122_3344));
    rows.push_back(word_row(OP_LOAD, 32'h8899_AABB));
    repeat (7) rows.push_back(word_row(OP_EMIT, $urandom));
    // shrink mid-row, then zero and oversize dimensions
    rows.push_back(reg_row(REG_DST_WIDTH, 13'd1));
    rows.push_back(word_row(OP_EMIT, $urandom));
    rows.push_back(reg_row(REG_SRC_WIDTH, 13'd0));
    rows.push_back(reg_row(REG_SRC_HEIGHT, '1));
    rows.push_back(reg_row(REG_DST_WIDTH, '1));
    rows.push_back(reg_row(REG_DST_HEIGHT, 13'd0));
    repeat (2) rows.push_back(word_row(OP_EMIT, $urandom));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) write_reg(rows[i].index, rows[i].data);
      else send_word(rows[i].opcode, rows[i].pixel, rows[i].known, rows[i].result);
    end

    while (words_sent < WORD_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> nearest_neighbor_image_scaler_unit.f
design/nnis_pkg.sv
design/nnis_fifo.sv
design/nnis_front.sv
design/nnis_back.sv
design/nearest_neighbor_image_scaler_unit.sv
tb/nearest_neighbor_image_scaler_unit_tb.sv
